// ===== design/sorted_range_key_table_core_macros.svh =====
// ---------------------------------------------------------------------------
// sorted range key table - assertion macros
// shared property shorthands for the checks at the end of the core
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_RANGE_KEY_TABLE_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define SRKT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srkt same-cycle check failed");

// next-cycle implication under synchronous reset
`define SRKT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srkt next-cycle check failed");

`endif

// ===== design/srkt_pkg.sv =====
// ---------------------------------------------------------------------------
// srkt_pkg
// request and response types, status and kind codes, cell flag type
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srkt_pkg;

   localparam int SEQ_BITS = 9;
   localparam int POS_BITS = 9;

   // request kinds
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_ENTRY = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [63:0] key;
      logic [31:0] name_handle;
      logic [31:0] entry_count;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                exact_match;
      logic [POS_BITS-1:0] position;
      logic [31:0]         found_name;
      logic [31:0]         found_count;
      logic [SEQ_BITS-1:0] sequence_res;
   } rsp_type;

   // per-cell compare flags, captured once per request
   typedef struct packed {
      logic valid;
      logic lt;
      logic eq;
   } cell_flag_type;

endpackage

// ===== design/sorted_range_key_table_core.sv =====
// ---------------------------------------------------------------------------
// sorted_range_key_table_core
// sorted end-key table with range lookup and ordered insert
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one response, shown for a single cycle with rsp_valid high; the
// receiver cannot stall it, so it must take it in that cycle. From acceptance,
// a request passes through the compare stage, the registered selection tree,
// which drains one level per cycle, and the decision and response stages to
// the response strobe; a new request can be taken in the strobe cycle.
// Entries live in a chain of slots that compare in parallel and shift up by
// one on insert. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_range_key_table_core_macros.svh"

module sorted_range_key_table_core #(
   parameter int DEPTH     = 256,
   parameter int KEY_BITS  = 64,
   parameter int NAME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  srkt_pkg::req_type req_data,
   output logic              rsp_valid,
   output srkt_pkg::rsp_type rsp_data
);
   import srkt_pkg::*;

   localparam int AW     = $clog2(DEPTH);
   localparam int UW     = $clog2(DEPTH + 1);
   localparam int CW     = $clog2(AW + 1);
   localparam int NAME_W = (NAME_BITS < 32) ? NAME_BITS : 32;
   localparam int W      = 1 + NAME_W + 32 + SEQ_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_TREE = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [UW-1:0]       used_ff, used_in;
   req_type             req_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [KEY_BITS-1:0] new_key;
   logic [NAME_W-1:0]   new_name;
   logic [SEQ_BITS-1:0] new_seq;
   logic [UW-1:0]       used_inc;
   logic                update;
   logic                accept;

   logic [KEY_BITS-1:0] key_q   [DEPTH];
   logic [NAME_W-1:0]   name_q  [DEPTH];
   logic [31:0]         count_q [DEPTH];
   logic [SEQ_BITS-1:0] seq_q   [DEPTH];
   cell_flag_type       flag_q  [DEPTH];
   logic [DEPTH-1:0]    sel_q;
   logic [DEPTH-1:0][W-1:0] sel_data;

   logic                hit;
   logic [AW-1:0]       hit_pos;
   logic [W-1:0]        hit_data;
   logic                hit_eq;
   logic [NAME_W-1:0]   hit_name;
   logic [31:0]         hit_count;
   logic [SEQ_BITS-1:0] hit_seq;
   logic [AW-1:0]       ins_pos;

   assign accept   = start && (state_ff == S_IDLE);
   assign new_key  = req_ff.key[KEY_BITS-1:0];
   assign new_name = req_ff.name_handle[NAME_W-1:0];
   assign used_inc = used_ff + 1'b1;
   assign new_seq  = SEQ_BITS'(used_inc);

   // chain of slots
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         srkt_cell #(
            .IDX(i), .KEY_BITS(KEY_BITS), .NAME_W(NAME_W), .UW(UW)
         ) u_cell (
            .clock(clock), .reset(reset), .used(used_ff),
            .cmp_en(state_ff == S_CMP), .update(update),
            .new_key(new_key), .new_name(new_name),
            .new_count(req_ff.entry_count), .new_seq(new_seq),
            .prev_lt(1'b1), .prev_key(new_key), .prev_name(new_name),
            .prev_count(req_ff.entry_count), .prev_seq(new_seq),
            .key(key_q[i]), .name(name_q[i]), .count(count_q[i]),
            .seq(seq_q[i]), .flag(flag_q[i]), .sel(sel_q[i])
         );
      end else begin : g_body
         srkt_cell #(
            .IDX(i), .KEY_BITS(KEY_BITS), .NAME_W(NAME_W), .UW(UW)
         ) u_cell (
            .clock(clock), .reset(reset), .used(used_ff),
            .cmp_en(state_ff == S_CMP), .update(update),
            .new_key(new_key), .new_name(new_name),
            .new_count(req_ff.entry_count), .new_seq(new_seq),
            .prev_lt(flag_q[i-1].lt), .prev_key(key_q[i-1]),
            .prev_name(name_q[i-1]), .prev_count(count_q[i-1]),
            .prev_seq(seq_q[i-1]),
            .key(key_q[i]), .name(name_q[i]), .count(count_q[i]),
            .seq(seq_q[i]), .flag(flag_q[i]), .sel(sel_q[i])
         );
      end
      assign sel_data[i] = {flag_q[i].eq, name_q[i], count_q[i], seq_q[i]};
   end

   // selection of the first slot at or above the key
   srkt_sel #(
      .DEPTH(DEPTH), .W(W)
   ) u_sel (
      .clock(clock), .sel(sel_q), .data(sel_data),
      .hit(hit), .pos(hit_pos), .data_out(hit_data)
   );

   assign {hit_eq, hit_name, hit_count, hit_seq} = hit_data;
   assign ins_pos = hit ? hit_pos : AW'(used_ff);

   // insert goes ahead only for a new key with room left
   assign update = (state_ff == S_FIN) && (req_ff.kind == KIND_INSERT)
                   && !(hit && hit_eq) && (used_ff != UW'(DEPTH));

   // sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_TREE;
            cnt_in   = '0;
         end
         S_TREE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(AW)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response build
   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = state_ff == S_FIN;
      used_in      = update ? used_inc : used_ff;
      if (req_ff.kind == KIND_LOOKUP || (hit && hit_eq)) begin
         if (hit) begin
            rsp_in.status       = ST_OK;
            rsp_in.exact_match  = hit_eq;
            rsp_in.position     = POS_BITS'(hit_pos);
            rsp_in.found_name   = 32'(hit_name);
            rsp_in.found_count  = hit_count;
            rsp_in.sequence_res = hit_seq;
         end else begin
            rsp_in.status = ST_NO_ENTRY;
         end
      end else if (used_ff == UW'(DEPTH)) begin
         rsp_in.status = ST_FULL;
      end else begin
         rsp_in.status       = ST_OK;
         rsp_in.position     = POS_BITS'(ins_pos);
         rsp_in.found_name   = 32'(new_name);
         rsp_in.found_count  = req_ff.entry_count;
         rsp_in.sequence_res = new_seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_FIN) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `SRKT_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_ff <= UW'(DEPTH))
   `SRKT_ASSERT_NEXT(a_fin_strobe, clock, reset, state_ff == S_FIN, rsp_valid_ff)
   `SRKT_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `SRKT_ASSERT_NEXT(a_used_hold, clock, reset, !reset && state_ff != S_FIN, $stable(used_ff))

endmodule

// ===== design/srkt_cell.sv =====
// ---------------------------------------------------------------------------
// srkt_cell
// one slot of the sorted chain: holds an entry, compares it against the
// request key and takes either the new entry or its lower neighbour on insert
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srkt_cell #(
   parameter int IDX      = 0,
   parameter int KEY_BITS = 64,
   parameter int NAME_W   = 32,
   parameter int UW       = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [UW-1:0]                 used,
   input  logic                          cmp_en,
   input  logic                          update,
   input  logic [KEY_BITS-1:0]           new_key,
   input  logic [NAME_W-1:0]             new_name,
   input  logic [31:0]                   new_count,
   input  logic [srkt_pkg::SEQ_BITS-1:0] new_seq,
   input  logic                          prev_lt,
   input  logic [KEY_BITS-1:0]           prev_key,
   input  logic [NAME_W-1:0]             prev_name,
   input  logic [31:0]                   prev_count,
   input  logic [srkt_pkg::SEQ_BITS-1:0] prev_seq,
   output logic [KEY_BITS-1:0]           key,
   output logic [NAME_W-1:0]             name,
   output logic [31:0]                   count,
   output logic [srkt_pkg::SEQ_BITS-1:0] seq,
   output srkt_pkg::cell_flag_type       flag,
   output logic                          sel
);
   import srkt_pkg::*;

   logic [KEY_BITS-1:0] key_ff;
   logic [NAME_W-1:0]   name_ff;
   logic [31:0]         count_ff;
   logic [SEQ_BITS-1:0] seq_ff;
   cell_flag_type       flag_ff;
   cell_flag_type       flag_in;
   logic                first;

   // compare against the broadcast key
   always_comb begin
      flag_in.valid = UW'(IDX) < used;
      flag_in.lt    = flag_in.valid && (key_ff < new_key);
      flag_in.eq    = key_ff == new_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else if (cmp_en) begin
         flag_ff <= flag_in;
      end
   end

   // first slot at or above the key (lt flags form a thermometer)
   assign first = !flag_ff.lt && prev_lt;
   assign sel   = first && flag_ff.valid;

   // insert: the boundary slot loads the new entry, slots above it shift up
   always_ff @(posedge clock) begin
      if (update && !flag_ff.lt) begin
         if (prev_lt) begin
            key_ff   <= new_key;
            name_ff  <= new_name;
            count_ff <= new_count;
            seq_ff   <= new_seq;
         end else begin
            key_ff   <= prev_key;
            name_ff  <= prev_name;
            count_ff <= prev_count;
            seq_ff   <= prev_seq;
         end
      end
   end

   assign key   = key_ff;
   assign name  = name_ff;
   assign count = count_ff;
   assign seq   = seq_ff;
   assign flag  = flag_ff;

endmodule

// ===== design/srkt_sel.sv =====
// ---------------------------------------------------------------------------
// srkt_sel
// registered or-tree over the one-hot slot select, one level per cycle,
// returning hit, slot index and the selected slot's data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srkt_sel #(
   parameter int DEPTH = 256,
   parameter int W     = 74
) (
   input  logic                          clock,
   input  logic [DEPTH-1:0]              sel,
   input  logic [DEPTH-1:0][W-1:0]       data,
   output logic                          hit,
   output logic [$clog2(DEPTH)-1:0]      pos,
   output logic [W-1:0]                  data_out
);
   import srkt_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int SIZE = 1 << AW;
   localparam int LW   = 1 + AW + W;

   logic [LW-1:0] node_ff [1:2*SIZE-1];

   // leaf level: masked slot data tagged with its index
   for (genvar i = 0; i < SIZE; i++) begin : g_leaf
      if (i < DEPTH) begin : g_used
         always_ff @(posedge clock) begin
            node_ff[SIZE+i] <= sel[i] ? {1'b1, AW'(i), data[i]} : '0;
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_ff[SIZE+i] <= '0;
         end
      end
   end

   // inner levels
   for (genvar n = 1; n < SIZE; n++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[n] <= node_ff[2*n] | node_ff[2*n+1];
      end
   end

   assign hit      = node_ff[1][LW-1];
   assign pos      = node_ff[1][LW-2 -: AW];
   assign data_out = node_ff[1][W-1:0];

endmodule
